@@ src/c2s_pkg.sv @@
`default_nettype none
package c2s_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIVW       = 32 + FRAC_BITS;
   localparam int ROOT_STEPS = 32;
   localparam int RAT_STEPS  = 31;
   localparam int LATENCY    = DIVW + 69;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_WZERO  = 2'd1,
      ST_ZAXIS  = 2'd2,
      ST_ORIGIN = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
      logic signed [31:0] w_coord;
   } point_type;

   typedef struct packed {
      logic [31:0]        radius;
      logic signed [31:0] cos_azimuth;
      logic signed [31:0] sin_azimuth;
      logic [30:0]        cos_elevation;
      logic signed [31:0] sin_elevation;
      status_type         status;
   } result_type;

   // Scaled division by the weight, three lanes sharing one divisor.
   typedef struct packed {
      logic                      wz;
      logic [2:0]                an;
      logic                      wn;
      logic [31:0]               wm;
      logic [2:0][31:0]          rem;
      logic [2:0][DIVW-1:0]      nq;
   } div_type;

   typedef struct packed {
      logic                      wz;
      logic [2:0]                qn;
      logic [2:0][31:0]          qm;
      logic [2:0][63:0]          sq;
   } sq_type;

   // Two floor square roots: lane 0 horizontal, lane 1 full radius.
   typedef struct packed {
      logic                      wz;
      logic [2:0]                qn;
      logic [2:0][31:0]          qm;
      logic [1:0][63:0]          v;
      logic [1:0][33:0]          rem;
      logic [1:0][31:0]          root;
   } sqrt_type;

   // Four Q30 ratios: x/Rh, y/Rh, Rh/R, z/R.
   typedef struct packed {
      status_type                status;
      logic [2:0]                qn;
      logic [31:0]               radius;
      logic [3:0][32:0]          rem;
      logic [3:0][30:0]          nq;
      logic [3:0][31:0]          dv;
   } rat_type;

   function automatic logic [31:0] pack_signed(input logic neg, input logic [30:0] mag);
      logic [31:0] m;
      m = {1'b0, mag};
      return neg ? (~m + 32'd1) : m;
   endfunction

endpackage
`default_nettype wire

@@ src/c2s_div_cell.sv @@
`default_nettype none
module c2s_div_cell
   import c2s_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire div_type in_data,
   output logic         out_valid,
   output div_type      out_data
);

   logic    valid_ff;
   div_type data_ff, data_in;

   always_comb begin
      logic [32:0] trial;
      logic        ge;
      data_in = in_data;
      for (int l = 0; l < 3; l++) begin
         trial = {in_data.rem[l], in_data.nq[l][DIVW-1]};
         ge    = trial >= {1'b0, in_data.wm};
         data_in.rem[l] = ge ? 32'(trial - {1'b0, in_data.wm}) : trial[31:0];
         data_in.nq[l]  = {in_data.nq[l][DIVW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

@@ src/c2s_sqrt_cell.sv @@
`default_nettype none
module c2s_sqrt_cell
   import c2s_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire sqrt_type in_data,
   output logic          out_valid,
   output sqrt_type      out_data
);

   logic     valid_ff;
   sqrt_type data_ff, data_in;

   // One root bit per cell: bring down two radicand bits, try 4*root+1.
   always_comb begin
      logic [35:0] trial;
      logic [35:0] t;
      logic        ge;
      data_in = in_data;
      for (int l = 0; l < 2; l++) begin
         trial = {in_data.rem[l], in_data.v[l][63:62]};
         t     = {2'b00, in_data.root[l], 2'b01};
         ge    = trial >= t;
         data_in.rem[l]  = ge ? 34'(trial - t) : trial[33:0];
         data_in.root[l] = {in_data.root[l][30:0], ge};
         data_in.v[l]    = {in_data.v[l][61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

@@ src/c2s_rat_cell.sv @@
`default_nettype none
module c2s_rat_cell
   import c2s_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rat_type in_data,
   output logic         out_valid,
   output rat_type      out_data
);

   logic    valid_ff;
   rat_type data_ff, data_in;

   always_comb begin
      logic [33:0] trial;
      logic        ge;
      data_in = in_data;
      for (int l = 0; l < 4; l++) begin
         trial = {in_data.rem[l], in_data.nq[l][30]};
         ge    = trial >= {2'b00, in_data.dv[l]};
         data_in.rem[l] = ge ? 33'(trial - {2'b00, in_data.dv[l]}) : trial[32:0];
         data_in.nq[l]  = {in_data.nq[l][29:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

@@ src/cartesian_to_spherical.sv @@
// Channel  | Ports                       | Beat taken when
// ---------+-----------------------------+----------------------------
// request  | start, busy, req_point      | start && !busy
// response | rsp_valid, rsp_result       | every cycle rsp_valid is high
//
// Fully pipelined: one point per cycle, busy is always low.
// The datapath is a chain of restoring division cells (one quotient
// bit each), 32 square root cells and 31 ratio division cells.
// Synchronous reset clears only the valid bits.
// The receiver cannot stall; a result is shown for exactly one cycle.
`default_nettype none
module cartesian_to_spherical
   import c2s_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   input  wire point_type req_point,
   output logic           rsp_valid,
   output result_type     rsp_result
);

   div_type  div_pipe  [DIVW+1];
   logic     div_vld   [DIVW+1];
   sqrt_type sqrt_pipe [ROOT_STEPS+1];
   logic     sqrt_vld  [ROOT_STEPS+1];
   rat_type  rat_pipe  [RAT_STEPS+1];
   logic     rat_vld   [RAT_STEPS+1];

   div_type    div0_in, div0_ff;
   logic       div0_vld_ff;
   sq_type     sat_in, sat_ff;
   logic       sat_vld_ff;
   sq_type     sq_in, sq_ff;
   logic       sq_vld_ff;
   sqrt_type   sum_in, sum_ff;
   logic       sum_vld_ff;
   rat_type    rat0_in, rat0_ff;
   logic       rat0_vld_ff;
   result_type res_in, res_ff;
   logic       res_vld_ff;

   assign busy = 1'b0;

   // Split into sign and magnitude and line up the scaled dividends.
   always_comb begin
      logic [3:0][31:0] raw;
      logic [31:0]      mag;
      raw = {req_point.x_coord, req_point.y_coord, req_point.z_coord, req_point.w_coord};
      div0_in = '0;
      for (int l = 0; l < 3; l++) begin
         mag = raw[3-l][31] ? (~raw[3-l] + 32'd1) : raw[3-l];
         div0_in.an[l] = raw[3-l][31];
         div0_in.nq[l] = {mag, {FRAC_BITS{1'b0}}};
      end
      div0_in.wn = raw[0][31];
      div0_in.wm = raw[0][31] ? (~raw[0] + 32'd1) : raw[0];
      div0_in.wz = (raw[0] == '0);
   end

   assign div_pipe[0] = div0_ff;
   assign div_vld[0]  = div0_vld_ff;

   for (genvar i = 0; i < DIVW; i++) begin : g_div
      c2s_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_vld[i]),
         .in_data   (div_pipe[i]),
         .out_valid (div_vld[i+1]),
         .out_data  (div_pipe[i+1])
      );
   end

   // Saturate the quotients to the signed 32-bit range.
   always_comb begin
      logic            neg;
      logic [DIVW-1:0] lim;
      logic [DIVW-1:0] q;
      sat_in = '0;
      sat_in.wz = div_pipe[DIVW].wz;
      for (int l = 0; l < 3; l++) begin
         q   = div_pipe[DIVW].nq[l];
         neg = (div_pipe[DIVW].an[l] ^ div_pipe[DIVW].wn) && (q != '0);
         lim = neg ? DIVW'(33'h0_8000_0000) : DIVW'(33'h0_7FFF_FFFF);
         sat_in.qn[l] = neg;
         sat_in.qm[l] = (q > lim) ? lim[31:0] : q[31:0];
      end
   end

   always_comb begin
      sq_in = sat_ff;
      for (int l = 0; l < 3; l++) begin
         sq_in.sq[l] = {32'd0, sat_ff.qm[l]} * {32'd0, sat_ff.qm[l]};
      end
   end

   always_comb begin
      logic [63:0] hs;
      hs = sq_ff.sq[0] + sq_ff.sq[1];
      sum_in      = '0;
      sum_in.wz   = sq_ff.wz;
      sum_in.qn   = sq_ff.qn;
      sum_in.qm   = sq_ff.qm;
      sum_in.v[0] = hs;
      sum_in.v[1] = hs + sq_ff.sq[2];
   end

   assign sqrt_pipe[0] = sum_ff;
   assign sqrt_vld[0]  = sum_vld_ff;

   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_sqrt
      c2s_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sqrt_vld[i]),
         .in_data   (sqrt_pipe[i]),
         .out_valid (sqrt_vld[i+1]),
         .out_data  (sqrt_pipe[i+1])
      );
   end

   // Every ratio is at most 2^30, so the top part of each dividend already
   // sits below its divisor and only 31 quotient bits remain.
   always_comb begin
      logic [3:0][31:0] num;
      sqrt_type         s;
      s   = sqrt_pipe[ROOT_STEPS];
      num = {s.qm[2], s.root[0], s.qm[1], s.qm[0]};
      rat0_in    = '0;
      rat0_in.qn = s.qn;
      rat0_in.dv = {s.root[1], s.root[1], s.root[0], s.root[0]};
      for (int l = 0; l < 4; l++) begin
         rat0_in.rem[l] = {2'b00, num[l][31:1]};
         rat0_in.nq[l]  = {num[l][0], 30'd0};
      end
      rat0_in.radius = s.root[1];
      if (s.wz) begin
         rat0_in.status = ST_WZERO;
      end else if (s.qm[0] == '0 && s.qm[1] == '0 && s.qm[2] == '0) begin
         rat0_in.status = ST_ORIGIN;
      end else if (s.qm[0] == '0 && s.qm[1] == '0) begin
         rat0_in.status = ST_ZAXIS;
         rat0_in.radius = s.qm[2];
      end else begin
         rat0_in.status = ST_OK;
      end
   end

   assign rat_pipe[0] = rat0_ff;
   assign rat_vld[0]  = rat0_vld_ff;

   for (genvar i = 0; i < RAT_STEPS; i++) begin : g_rat
      c2s_rat_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rat_vld[i]),
         .in_data   (rat_pipe[i]),
         .out_valid (rat_vld[i+1]),
         .out_data  (rat_pipe[i+1])
      );
   end

   always_comb begin
      rat_type r;
      r = rat_pipe[RAT_STEPS];
      res_in = '0;
      res_in.status = r.status;
      unique case (r.status)
         ST_OK: begin
            res_in.radius        = r.radius;
            res_in.cos_azimuth   = pack_signed(r.qn[0], r.nq[0]);
            res_in.sin_azimuth   = pack_signed(r.qn[1], r.nq[1]);
            res_in.cos_elevation = r.nq[2];
            res_in.sin_elevation = pack_signed(r.qn[2], r.nq[3]);
         end
         ST_ZAXIS: begin
            res_in.radius        = r.radius;
            res_in.sin_elevation = pack_signed(r.qn[2], 31'h4000_0000);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div0_vld_ff <= 1'b0;
         sat_vld_ff  <= 1'b0;
         sq_vld_ff   <= 1'b0;
         sum_vld_ff  <= 1'b0;
         rat0_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         div0_vld_ff <= start;
         sat_vld_ff  <= div_vld[DIVW];
         sq_vld_ff   <= sat_vld_ff;
         sum_vld_ff  <= sq_vld_ff;
         rat0_vld_ff <= sqrt_vld[ROOT_STEPS];
         res_vld_ff  <= rat_vld[RAT_STEPS];
      end
      div0_ff <= div0_in;
      sat_ff  <= sat_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      rat0_ff <= rat0_in;
      res_ff  <= res_in;
   end

   assign rsp_valid  = res_vld_ff;
   assign rsp_result = res_ff;

`ifndef SYNTHESIS
   a_resp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response beat without a request beat");

   a_wzero_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result.status == ST_WZERO) |-> rsp_result.radius == '0)
      else $error("weight zero result carries a radius");

   a_ok_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result.status == ST_OK) |-> rsp_result.radius != '0)
      else $error("regular result with zero radius");
`endif

endmodule
`default_nettype wire
